>>> hdl/bounded_array_deque_core_assert.svh
// assertion macros for the deque core
// needs clk_i and rst_ni in the including module's scope
`ifndef BOUNDED_ARRAY_DEQUE_CORE_ASSERT_SVH
`define BOUNDED_ARRAY_DEQUE_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BDQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define BDQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/bdeque_pkg.sv
// shared types and constants of the deque core
// no dependencies
package bdeque_pkg;

  localparam int DataW = 32;
  localparam int CountW = 5;
  localparam int OpW = 3;
  localparam int StatusW = 2;

  typedef enum logic [OpW-1:0] {
    OpPushBack  = 3'd0,
    OpPushFront = 3'd1,
    OpPopBack   = 3'd2,
    OpPopFront  = 3'd3,
    OpPeekBack  = 3'd4,
    OpPeekFront = 3'd5
  } op_e;

  typedef enum logic [StatusW-1:0] {
    StDone  = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2
  } status_e;

  // where the data of a result comes from
  typedef enum logic [1:0] {
    SelZero,
    SelMem,
    SelOnes
  } data_sel_e;

endpackage

>>> hdl/bdeque_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module bdeque_ram #(
  parameter int Width = 32,
  parameter int Depth = 16,
  parameter int AddrW = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/bounded_array_deque_core.sv
// bounded double-ended queue of 32-bit values, circular buffer in a ram
// depends on bdeque_pkg, bdeque_ram and bounded_array_deque_core_assert.svh
//
//  port group        dir  handshake              contents
//  start_i/op/value  in   start_i && !busy_o     operation_i, value_i
//  done_o/results    out  done_o, one cycle      data_o, status_o, count_o, flags
//  cap_we_i          in   cap_we_i               cap_wdata_i (capacity)
//
//  a request is taken in any cycle; its result shows on the cycle after.
//  pointer update, ram write or ram read all happen at the accepting edge,
//  so the registered ram read sets the request-to-result delay.
//  busy_o stays low: one request per cycle, sustained.
//  reset empties the queue and sets capacity to 16; no clearing pass.
module bounded_array_deque_core #(
  parameter int DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [2:0]         operation_i,
  input  logic signed [31:0] value_i,
  input  logic               cap_we_i,
  input  logic [4:0]         cap_wdata_i,
  output logic               done_o,
  output logic signed [31:0] data_o,
  output logic [1:0]         status_o,
  output logic [4:0]         count_o,
  output logic               is_empty_o,
  output logic               is_full_o
);

  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = bdeque_pkg::CountW;
  localparam int SumW = ((AddrW > CntW) ? AddrW : CntW) + 1;
  localparam logic [CntW-1:0] DepthCap = (DEPTH > 31) ? 5'd31 : CntW'(DEPTH);
  localparam logic [AddrW-1:0] LastIdx = AddrW'(DEPTH - 1);
  localparam logic [SumW-1:0] DepthSum = SumW'(DEPTH);

  logic [AddrW-1:0] head_q, head_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  cap_q;
  logic             done_q;
  logic             full_q, full_d;
  bdeque_pkg::status_e   status_q, status_d;
  bdeque_pkg::data_sel_e sel_q, sel_d;
  bdeque_pkg::op_e       op;

  logic             accept;
  logic [CntW-1:0]  limit;
  logic             full, empty;
  logic [SumW-1:0]  tail_sum;
  logic [AddrW-1:0] tail_idx, back_idx, head_inc, head_dec;
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [bdeque_pkg::DataW-1:0] ram_rdata;

  assign accept = start_i && !busy_o;
  assign busy_o = 1'b0;
  assign op = bdeque_pkg::op_e'(operation_i);

  assign limit = (cap_q > DepthCap) ? DepthCap : cap_q;
  assign full  = count_q >= limit;
  assign empty = count_q == '0;

  // head plus count stays below twice the depth, one subtract wraps it
  assign tail_sum = SumW'(head_q) + SumW'(count_q);
  assign tail_idx = (tail_sum >= DepthSum) ? AddrW'(tail_sum - DepthSum)
                                           : AddrW'(tail_sum);
  assign back_idx = (tail_idx == '0) ? LastIdx : tail_idx - 1'b1;
  assign head_inc = (head_q == LastIdx) ? '0 : head_q + 1'b1;
  assign head_dec = (head_q == '0) ? LastIdx : head_q - 1'b1;

  always_comb begin
    head_d    = head_q;
    count_d   = count_q;
    status_d  = bdeque_pkg::StDone;
    sel_d     = bdeque_pkg::SelZero;
    ram_we    = 1'b0;
    ram_waddr = tail_idx;
    ram_re    = 1'b0;
    ram_raddr = head_q;
    if (accept) begin
      case (op)
        bdeque_pkg::OpPushBack: begin
          if (full) begin
            status_d = bdeque_pkg::StFull;
          end else begin
            ram_we  = 1'b1;
            count_d = count_q + 1'b1;
          end
        end
        bdeque_pkg::OpPushFront: begin
          if (full) begin
            status_d = bdeque_pkg::StFull;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = head_dec;
            head_d    = head_dec;
            count_d   = count_q + 1'b1;
          end
        end
        bdeque_pkg::OpPopBack: begin
          if (empty) begin
            status_d = bdeque_pkg::StEmpty;
          end else begin
            count_d = count_q - 1'b1;
          end
        end
        bdeque_pkg::OpPopFront: begin
          if (empty) begin
            status_d = bdeque_pkg::StEmpty;
          end else begin
            head_d  = head_inc;
            count_d = count_q - 1'b1;
          end
        end
        bdeque_pkg::OpPeekBack, bdeque_pkg::OpPeekFront: begin
          if (empty) begin
            status_d = bdeque_pkg::StEmpty;
            sel_d    = bdeque_pkg::SelOnes;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = (op == bdeque_pkg::OpPeekBack) ? back_idx : head_q;
            sel_d     = bdeque_pkg::SelMem;
          end
        end
        default: begin
        end
      endcase
    end
    full_d = count_d >= limit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      cap_q   <= 5'd16;
      done_q  <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      done_q  <= accept;
      if (cap_we_i) begin
        cap_q <= cap_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      sel_q    <= sel_d;
      full_q   <= full_d;
    end
  end

  bdeque_ram #(
    .Width (bdeque_pkg::DataW),
    .Depth (DEPTH),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (value_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    case (sel_q)
      bdeque_pkg::SelMem:  data_o = ram_rdata;
      bdeque_pkg::SelOnes: data_o = '1;
      default:             data_o = '0;
    endcase
  end

  assign done_o     = done_q;
  assign status_o   = status_q;
  assign count_o    = count_q;
  assign is_empty_o = count_q == '0;
  assign is_full_o  = full_q;

`include "bounded_array_deque_core_assert.svh"

  `BDQ_ASSERT_NEXT(a_result_follows, accept, done_o, "request gave no result")
  `BDQ_ASSERT_NEXT(a_push_counts, accept && ram_we, count_q == $past(count_q) + 1'b1, "push did not grow count")
  `BDQ_ASSERT_NEXT(a_reject_holds, accept && status_d != bdeque_pkg::StDone, count_q == $past(count_q) && head_q == $past(head_q), "rejected request changed state")
  `BDQ_ASSERT_NOW(a_empty_peek, done_o && sel_q == bdeque_pkg::SelOnes, status_o == bdeque_pkg::StEmpty && data_o == '1, "empty peek result wrong")
  `BDQ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= DepthCap && head_q <= LastIdx, "pointer or count out of range")

endmodule

>>> tb/testbench.sv
// self-checking testbench for bounded_array_deque_core
// depends on bdeque_pkg and the core; predicts every result with its own deque model
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = 16;
  localparam int PhaseItems = 90;
  localparam int CycleLimit = 200000;
  // codes the core leaves unused: it answers them without changing anything
  localparam logic [bdeque_pkg::OpW-1:0] OpSpare6 = 3'd6;
  localparam logic [bdeque_pkg::OpW-1:0] OpSpare7 = 3'd7;
  localparam logic signed [bdeque_pkg::DataW-1:0] MinusOne = -32'sd1;
  localparam logic signed [bdeque_pkg::DataW-1:0] MostPos = 32'sh7fffffff;
  localparam logic signed [bdeque_pkg::DataW-1:0] MostNeg = 32'sh80000000;

  typedef struct {
    logic signed [bdeque_pkg::DataW-1:0] data;
    bdeque_pkg::status_e                 status;
    logic [bdeque_pkg::CountW-1:0]       count;
    logic                                is_empty;
    logic                                is_full;
  } deque_result_t;

  class deque_scoreboard;
    logic signed [bdeque_pkg::DataW-1:0] slots[Depth];
    int unsigned                         fill;
    logic [bdeque_pkg::CountW-1:0]       capacity;
    deque_result_t                       awaited[$];
    int                                  mismatches;

    function new();
      foreach (slots[i]) slots[i] = '0;
      fill = 0;
      capacity = 5'd16;
      mismatches = 0;
    endfunction

    function void set_capacity(logic [bdeque_pkg::CountW-1:0] cap);
      capacity = cap;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // applies one accepted request to the model and queues its result
    function void note_request(logic [bdeque_pkg::OpW-1:0] op,
                               logic signed [bdeque_pkg::DataW-1:0] value);
      deque_result_t res;
      int unsigned   lim;
      bit            at_limit;
      bit            no_items;
      lim = (capacity > Depth) ? Depth : capacity;
      at_limit = fill >= lim;
      no_items = fill == 0;
      res.data = '0;
      res.status = bdeque_pkg::StDone;
      case (op)
        bdeque_pkg::OpPushBack: begin
          if (at_limit) begin
            res.status = bdeque_pkg::StFull;
          end else begin
            slots[fill] = value;
            fill++;
          end
        end
        bdeque_pkg::OpPushFront: begin
          if (at_limit) begin
            res.status = bdeque_pkg::StFull;
          end else begin
            for (int i = fill; i > 0; i--) slots[i] = slots[i-1];
            slots[0] = value;
            fill++;
          end
        end
        bdeque_pkg::OpPopBack, bdeque_pkg::OpPopFront: begin
          if (no_items) begin
            res.status = bdeque_pkg::StEmpty;
          end else begin
            if (op == bdeque_pkg::OpPopFront) begin
              for (int i = 0; i + 1 < fill; i++) slots[i] = slots[i+1];
            end
            fill--;
          end
        end
        bdeque_pkg::OpPeekBack, bdeque_pkg::OpPeekFront: begin
          if (no_items) begin
            res.status = bdeque_pkg::StEmpty;
            res.data = MinusOne;
          end else begin
            res.data = (op == bdeque_pkg::OpPeekBack) ? slots[fill-1] : slots[0];
          end
        end
        default: ;
      endcase
      res.count = fill[bdeque_pkg::CountW-1:0];
      res.is_empty = fill == 0;
      res.is_full = fill >= lim;
      awaited.push_back(res);
    endfunction

    function void check_result(logic signed [bdeque_pkg::DataW-1:0] data,
                               logic [bdeque_pkg::StatusW-1:0] status,
                               logic [bdeque_pkg::CountW-1:0] count,
                               logic is_empty, logic is_full);
      deque_result_t exp;
      if (awaited.size() == 0) begin
        $error("result with nothing outstanding: data %0d status %0d count %0d",
               data, status, count);
        mismatches++;
        return;
      end
      exp = awaited.pop_front();
      if (data !== exp.data) begin
        $error("data: expected %0d, got %0d", exp.data, data);
        mismatches++;
      end
      if (status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, status);
        mismatches++;
      end
      if (count !== exp.count) begin
        $error("count: expected %0d, got %0d", exp.count, count);
        mismatches++;
      end
      if (is_empty !== exp.is_empty) begin
        $error("is_empty: expected %0b, got %0b", exp.is_empty, is_empty);
        mismatches++;
      end
      if (is_full !== exp.is_full) begin
        $error("is_full: expected %0b, got %0b", exp.is_full, is_full);
        mismatches++;
      end
    endfunction

    function void flag_leftover();
      if (awaited.size() != 0) begin
        $error("%0d results never arrived", awaited.size());
        mismatches++;
      end
    endfunction
  endclass

  logic                                clk_i;
  logic                                rst_ni;
  logic                                start_i;
  logic                                busy_o;
  logic [bdeque_pkg::OpW-1:0]          operation_i;
  logic signed [bdeque_pkg::DataW-1:0] value_i;
  logic                                cap_we_i;
  logic [bdeque_pkg::CountW-1:0]       cap_wdata_i;
  logic                                done_o;
  logic signed [bdeque_pkg::DataW-1:0] data_o;
  logic [bdeque_pkg::StatusW-1:0]      status_o;
  logic [bdeque_pkg::CountW-1:0]       count_o;
  logic                                is_empty_o;
  logic                                is_full_o;

  deque_scoreboard sb = new();
  bit              steady;     // no gaps between requests
  int              push_bias;  // percent of non-spare requests that push
  int              cycle_count;

  bounded_array_deque_core #(.DEPTH(Depth)) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .operation_i (operation_i),
    .value_i     (value_i),
    .cap_we_i    (cap_we_i),
    .cap_wdata_i (cap_wdata_i),
    .done_o      (done_o),
    .data_o      (data_o),
    .status_o    (status_o),
    .count_o     (count_o),
    .is_empty_o  (is_empty_o),
    .is_full_o   (is_full_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(data_o, status_o, count_o, is_empty_o, is_full_o);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("testbench: FAIL");
    $finish;
  end

  // idles with no request; the payload carries junk the core must ignore
  task automatic idle_cycle();
    start_i <= 1'b0;
    operation_i <= bdeque_pkg::OpW'($urandom);
    value_i <= $urandom;
    @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_request(logic [bdeque_pkg::OpW-1:0] op,
                              logic signed [bdeque_pkg::DataW-1:0] value);
    start_i <= 1'b1;
    operation_i <= op;
    value_i <= value;
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
    sb.note_request(op, value);
    @(negedge clk_i);
  endtask

  task automatic write_capacity(logic [bdeque_pkg::CountW-1:0] cap);
    while (sb.pending() != 0) idle_cycle();
    idle_cycle();
    cap_we_i <= 1'b1;
    cap_wdata_i <= cap;
    @(posedge clk_i);
    sb.set_capacity(cap);
    @(negedge clk_i);
    cap_we_i <= 1'b0;
    cap_wdata_i <= bdeque_pkg::CountW'($urandom);
  endtask

  function automatic logic signed [bdeque_pkg::DataW-1:0] pick_value();
    case ($urandom_range(0, 15))
      0: return MostPos;
      1: return MostNeg;
      2: return '0;
      3: return MinusOne;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [bdeque_pkg::OpW-1:0] pick_operation();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return ($urandom_range(0, 1) != 0) ? OpSpare6 : OpSpare7;
    if ($urandom_range(0, 99) < push_bias) begin
      return ($urandom_range(0, 1) != 0) ? bdeque_pkg::OpPushBack : bdeque_pkg::OpPushFront;
    end
    case ($urandom_range(0, 3))
      0: return bdeque_pkg::OpPopBack;
      1: return bdeque_pkg::OpPopFront;
      2: return bdeque_pkg::OpPeekBack;
      default: return bdeque_pkg::OpPeekFront;
    endcase
  endfunction

  task automatic random_phase(int items);
    int left_in_mood;
    left_in_mood = 0;
    for (int n = 0; n < items; n++) begin
      // swing between filling and draining so both full and empty are visited
      if (left_in_mood == 0) begin
        left_in_mood = $urandom_range(15, 40);
        case ($urandom_range(0, 2))
          0: push_bias = 20;
          1: push_bias = 50;
          default: push_bias = 85;
        endcase
      end
      left_in_mood--;
      if (!steady) begin
        while ($urandom_range(0, 99) < 36) idle_cycle();
      end
      send_request(pick_operation(), pick_value());
    end
  endtask

  initial begin
    logic [bdeque_pkg::CountW-1:0] phase_caps[9];
    int                            k;
    phase_caps = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd7, 5'd17, 5'd15, 5'd3, 5'd20};
    rst_ni = 1'b0;
    start_i = 1'b0;
    operation_i = '0;
    value_i = '0;
    cap_we_i = 1'b0;
    cap_wdata_i = '0;
    steady = 1'b0;
    push_bias = 50;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    idle_cycle();

    // reset capacity: empty errors, extreme values at both ends, spare codes
    send_request(bdeque_pkg::OpPeekBack, '0);
    send_request(bdeque_pkg::OpPeekFront, '0);
    send_request(bdeque_pkg::OpPopBack, '0);
    send_request(bdeque_pkg::OpPopFront, '0);
    send_request(bdeque_pkg::OpPushBack, MostPos);
    send_request(bdeque_pkg::OpPushFront, MostNeg);
    send_request(bdeque_pkg::OpPeekBack, '0);
    send_request(bdeque_pkg::OpPeekFront, '0);
    send_request(bdeque_pkg::OpPushBack, '0);
    send_request(bdeque_pkg::OpPushFront, MinusOne);
    send_request(OpSpare6, MostPos);
    send_request(OpSpare7, MinusOne);
    send_request(bdeque_pkg::OpPopFront, '0);
    send_request(bdeque_pkg::OpPeekFront, '0);
    send_request(bdeque_pkg::OpPopBack, '0);
    // capacity dropped to the current count, then below it
    write_capacity(5'd2);
    send_request(bdeque_pkg::OpPushBack, 32'sd5);
    send_request(bdeque_pkg::OpPopFront, '0);
    send_request(bdeque_pkg::OpPushFront, 32'sd7);
    send_request(bdeque_pkg::OpPeekBack, '0);
    write_capacity(5'd0);
    send_request(bdeque_pkg::OpPushBack, 32'sd9);
    send_request(bdeque_pkg::OpPushFront, 32'sd9);
    send_request(bdeque_pkg::OpPeekFront, '0);
    send_request(bdeque_pkg::OpPopBack, '0);
    send_request(bdeque_pkg::OpPopFront, '0);
    send_request(bdeque_pkg::OpPopFront, '0);

    for (int p = 0; p < 15; p++) begin
      write_capacity((p < 9) ? phase_caps[p] : bdeque_pkg::CountW'($urandom_range(0, 31)));
      steady = (p == 2) || ($urandom_range(0, 4) == 0);
      random_phase(PhaseItems);
    end

    start_i <= 1'b0;
    for (k = 0; k < 20 && sb.pending() != 0; k++) @(posedge clk_i);
    sb.flag_leftover();
    repeat (3) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule
